[sv/lpfd_pkg.sv]
// Package for the length-prefixed frame deframer.
// Holds the phase type, register indexes, field widths and the result struct.
// No dependencies.
package lpfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECEIVE_ENABLE   = 8'd1;

  localparam logic [LEN_W-1:0] MAX_FRAME_LENGTH_RESET = 16'd1518;

  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_DELIVER = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              empty_frame;
  } result_t;

endpackage

[sv/lpfd_ifs.sv]
// Channel interfaces of the length-prefixed frame deframer: byte stream in,
// delivered frame bytes out, and the register write channel.
// Depends on lpfd_pkg.
interface lpfd_rx_if import lpfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfd_out_if import lpfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              frame_last;
  logic              empty_frame;

  modport source (output valid, output payload_byte, output frame_last,
                  output empty_frame, input ready);
  modport sink (input valid, input payload_byte, input frame_last,
                input empty_frame, output ready);
endinterface

interface lpfd_cfg_if import lpfd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/length_prefixed_frame_deframer.sv]
// Length-prefixed frame deframer, top level.
// Depends on lpfd_pkg and the channel interfaces in lpfd_ifs.sv.
//
// Usage:
//   rx carries the received stream, one byte per request. Each frame is a
//   16-bit little-endian length followed by that many payload bytes.
//   frame carries delivered payload bytes; frame_last marks the final byte
//   of a frame, and a delivered zero-length frame gives one request with
//   empty_frame and frame_last set and payload_byte zero.
//   cfg writes max_frame_length (index 0) and receive_enable (index 1); it
//   is always ready, and other indexes are ignored. Both registers are
//   sampled when the high length byte is processed.
// Timing:
//   One byte per cycle sustained while frame.ready is high. A byte is
//   captured in the input register, then processed into the result
//   register, from which its result is offered. Headers produce nothing
//   except the result of a delivered zero-length frame, and skipped frames
//   produce nothing.
// Reset:
//   rst (synchronous) empties both registers, expects a low length byte,
//   and restores max_frame_length to 1518 and receive_enable to 0.
// Stall:
//   While frame.ready is low the result holds; one more byte is taken into
//   the input register, then rx.ready drops until the result drains.
module length_prefixed_frame_deframer import lpfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lpfd_rx_if.sink      rx,
  lpfd_out_if.source   frame,
  lpfd_cfg_if.sink     cfg
);

  logic [LEN_W-1:0]  max_frame_length;
  logic              receive_enable;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_advance;
  logic              s1_fire;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  expected_length, expected_length_next;
  logic [LEN_W-1:0]  received_count, received_count_next;
  logic [LEN_W-1:0]  header_length;
  logic [LEN_W-1:0]  count_inc;
  logic              res_valid;
  result_t           res;

  logic              out_valid;
  result_t           out_res;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_LENGTH_RESET;
      receive_enable   <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MAX_FRAME_LENGTH) begin
        max_frame_length <= cfg.data[LEN_W-1:0];
      end else if (cfg.index == REG_RECEIVE_ENABLE) begin
        receive_enable <= cfg.data[0];
      end
    end
  end

  // Input register
  assign s1_advance = !out_valid || frame.ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign rx.ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_LO;
      expected_length <= '0;
      received_count  <= '0;
    end else if (s1_fire) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
    end
  end

  assign header_length = {s1_byte, expected_length[BYTE_W-1:0]};
  assign count_inc     = received_count + LEN_W'(1);

  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    res_valid            = 1'b0;
    res.payload_byte     = s1_byte;
    res.frame_last       = 1'b0;
    res.empty_frame      = 1'b0;
    case (phase)
      PH_LEN_LO: begin
        expected_length_next = {{(LEN_W-BYTE_W){1'b0}}, s1_byte};
        received_count_next  = '0;
        phase_next           = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        received_count_next = '0;
        if (header_length > max_frame_length) begin
          expected_length_next = header_length;
          phase_next           = PH_SKIP;
        end else if (header_length == '0) begin
          expected_length_next = '0;
          phase_next           = PH_LEN_LO;
          res_valid            = receive_enable;
          res.payload_byte     = '0;
          res.frame_last       = 1'b1;
          res.empty_frame      = 1'b1;
        end else begin
          expected_length_next = header_length;
          phase_next           = receive_enable ? PH_DELIVER : PH_SKIP;
        end
      end
      PH_DELIVER, PH_SKIP: begin
        received_count_next = count_inc;
        res_valid           = (phase == PH_DELIVER);
        res.frame_last      = (count_inc == expected_length);
        if (count_inc == expected_length) begin
          phase_next           = PH_LEN_LO;
          expected_length_next = '0;
          received_count_next  = '0;
        end
      end
      default: begin
        phase_next = PH_LEN_LO;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_res <= res;
    end
  end

  assign frame.valid        = out_valid;
  assign frame.payload_byte = out_res.payload_byte;
  assign frame.frame_last   = out_res.frame_last;
  assign frame.empty_frame  = out_res.empty_frame;

  // Checks
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.empty_frame |-> out_res.frame_last && out_res.payload_byte == '0)
    else $error("empty frame result without last mark or with nonzero byte");

  a_body_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DELIVER || phase == PH_SKIP) |-> expected_length != '0)
    else $error("frame body phase with zero length");

  a_count_below_length: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DELIVER || phase == PH_SKIP) |-> received_count < expected_length)
    else $error("received count reached frame length without finishing");

  a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> s1_valid && out_valid)
    else $error("input stalled with an empty pipeline stage");

  a_header_no_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && phase == PH_LEN_LO |=> !out_valid)
    else $error("result produced by a low length byte");

endmodule
